[sv/radix_digit_emitter_unit_assert.svh]
// ----------------------------------------------------------------------------
// radix digit emitter assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_EMITTER_UNIT_ASSERT_SVH
`define RADIX_DIGIT_EMITTER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define RDX_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rdx assertion failed");

// next-cycle implication, disabled while reset is held
`define RDX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rdx assertion failed");

`endif

[sv/rdx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdx_pkg
// types and constants shared by the radix digit emitter modules
// ----------------------------------------------------------------------------
package rdx_pkg;

  localparam int AlphabetSize = 16;
  localparam int CharW        = 8;
  localparam int DataW        = 32;
  localparam int DigitW       = $clog2(AlphabetSize);
  localparam int LenW         = 5;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 64;
  localparam int BitsPerStep  = 8;
  localparam int StepsPerDiv  = DataW / BitsPerStep;
  localparam int StepW        = $clog2(StepsPerDiv);
  localparam int DepthW       = $clog2(DataW + 1);

  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharPlus  = 8'h2B;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CtrlLo    = 8'd9;
  localparam logic [CharW-1:0] CtrlHi    = 8'd13;
  localparam logic [LenW-1:0]  MinRadix  = 5'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAlphaLow   = 2'd0,
    CfgAlphaHigh  = 2'd1,
    CfgBaseLength = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [AlphabetSize-1:0][CharW-1:0] alpha;
    logic [LenW-1:0]                    radix;
  } cfg_t;

  typedef struct packed {
    logic             invalid;
    logic             neg;
    logic [DataW-1:0] mag;
  } item_t;

  typedef enum logic [2:0] {
    StIdle,
    StInvalid,
    StSign,
    StDivide,
    StEmit
  } back_state_e;

endpackage

[sv/rdx_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdx_front
// configuration registers, alphabet check and input classification
// ----------------------------------------------------------------------------
module rdx_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rdx_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rdx_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rdx_pkg::DataW-1:0]    in_value_i,
  output logic                         q_valid_o,
  input  logic                         q_ready_i,
  output rdx_pkg::item_t               q_item_o,
  output rdx_pkg::cfg_t                cfg_o
);

  logic [rdx_pkg::CfgDataW-1:0] alpha_lo_q, alpha_lo_d;
  logic [rdx_pkg::CfgDataW-1:0] alpha_hi_q, alpha_hi_d;
  logic [rdx_pkg::LenW-1:0]     len_q, len_d;
  logic [rdx_pkg::AlphabetSize-1:0][rdx_pkg::CharW-1:0] alpha;
  logic                         alpha_ok;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    alpha_lo_d = alpha_lo_q;
    alpha_hi_d = alpha_hi_q;
    len_d      = len_q;
    if (cfg_valid_i) begin
      unique case (rdx_pkg::cfg_index_e'(cfg_index_i))
        rdx_pkg::CfgAlphaLow:   alpha_lo_d = cfg_data_i;
        rdx_pkg::CfgAlphaHigh:  alpha_hi_d = cfg_data_i;
        rdx_pkg::CfgBaseLength: len_d      = cfg_data_i[rdx_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_lo_q <= '0;
      alpha_hi_q <= '0;
      len_q      <= '0;
    end else begin
      alpha_lo_q <= alpha_lo_d;
      alpha_hi_q <= alpha_hi_d;
      len_q      <= len_d;
    end
  end

  assign alpha = {alpha_hi_q, alpha_lo_q};

  // radix range, forbidden bytes and pairwise duplicates among the characters in use
  always_comb begin
    logic [rdx_pkg::CharW-1:0] c;
    alpha_ok = (len_q >= rdx_pkg::MinRadix) &&
               (len_q <= rdx_pkg::LenW'(rdx_pkg::AlphabetSize));
    for (int i = 0; i < rdx_pkg::AlphabetSize; i++) begin
      c = alpha[i];
      if (rdx_pkg::LenW'(i) < len_q) begin
        if (c == rdx_pkg::CharNul || c == rdx_pkg::CharSpace ||
            c == rdx_pkg::CharPlus || c == rdx_pkg::CharMinus ||
            (c >= rdx_pkg::CtrlLo && c <= rdx_pkg::CtrlHi)) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < rdx_pkg::AlphabetSize; j++) begin
          if (rdx_pkg::LenW'(j) < len_q && alpha[j] == c) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  assign q_valid_o        = in_valid_i;
  assign in_ready_o       = q_ready_i;
  assign q_item_o.invalid = !alpha_ok;
  assign q_item_o.neg     = in_value_i[rdx_pkg::DataW-1];
  // two's complement negate; the most negative value maps to 2^31
  assign q_item_o.mag     = in_value_i[rdx_pkg::DataW-1] ?
                            (rdx_pkg::DataW'(0) - in_value_i) : in_value_i;

  assign cfg_o.alpha = alpha;
  assign cfg_o.radix = len_q;

endmodule

[sv/rdx_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdx_queue
// two-entry fifo between the classifier and the digit engine
// ----------------------------------------------------------------------------
module rdx_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rdx_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rdx_pkg::item_t out_item_o
);

  rdx_pkg::item_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

[sv/rdx_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdx_back
// digit engine: radix division, digit stack and output register
// ----------------------------------------------------------------------------
module rdx_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rdx_pkg::cfg_t              cfg_i,
  input  logic                       q_valid_i,
  output logic                       q_ready_o,
  input  rdx_pkg::item_t             q_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rdx_pkg::CharW-1:0]  out_char_o,
  output logic                       out_last_o,
  output logic                       out_inval_o
);

  rdx_pkg::back_state_e state_q, state_d;

  logic [rdx_pkg::DataW-1:0]  mag_q, mag_d;
  logic [rdx_pkg::DigitW-1:0] rem_q, rem_d;
  logic [rdx_pkg::StepW-1:0]  step_q, step_d;
  logic [rdx_pkg::DigitW-1:0] stack_q [rdx_pkg::DataW];
  logic [rdx_pkg::DepthW-1:0] depth_q, depth_d;

  logic                       out_valid_q, out_valid_d;
  logic [rdx_pkg::CharW-1:0]  out_char_q;
  logic                       out_last_q;
  logic                       out_inval_q;

  logic [rdx_pkg::DataW-1:0]  div_quot;
  logic [rdx_pkg::DigitW-1:0] div_rem;
  logic                       last_step;
  logic                       slot_free;
  logic                       take_item, div_run, push, pop;
  logic                       load_inval, load_sign, load_digit;

  assign slot_free = !out_valid_q || out_ready_i;
  assign last_step = (step_q == rdx_pkg::StepW'(rdx_pkg::StepsPerDiv - 1));

  // restoring division, BitsPerStep quotient bits per cycle
  always_comb begin
    logic [rdx_pkg::DataW-1:0]  d;
    logic [rdx_pkg::DigitW-1:0] r;
    logic [rdx_pkg::LenW-1:0]   t;
    d = mag_q;
    r = rem_q;
    for (int k = 0; k < rdx_pkg::BitsPerStep; k++) begin
      t = {r, d[rdx_pkg::DataW-1]};
      d = {d[rdx_pkg::DataW-2:0], 1'b0};
      if (t >= cfg_i.radix) begin
        t    = t - cfg_i.radix;
        d[0] = 1'b1;
      end
      r = t[rdx_pkg::DigitW-1:0];
    end
    div_quot = d;
    div_rem  = r;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rdx_pkg::StIdle: begin
        if (q_valid_i) begin
          priority if (q_item_i.invalid) state_d = rdx_pkg::StInvalid;
          else if (q_item_i.neg)         state_d = rdx_pkg::StSign;
          else                           state_d = rdx_pkg::StDivide;
        end
      end
      rdx_pkg::StInvalid: begin
        if (slot_free) state_d = rdx_pkg::StIdle;
      end
      rdx_pkg::StSign: begin
        if (slot_free) state_d = rdx_pkg::StDivide;
      end
      rdx_pkg::StDivide: begin
        if (last_step && div_quot == '0) state_d = rdx_pkg::StEmit;
      end
      rdx_pkg::StEmit: begin
        if (slot_free && depth_q == rdx_pkg::DepthW'(1)) state_d = rdx_pkg::StIdle;
      end
      default: state_d = rdx_pkg::StIdle;
    endcase
  end

  // state outputs
  always_comb begin
    q_ready_o  = 1'b0;
    take_item  = 1'b0;
    div_run    = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    load_inval = 1'b0;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    unique case (state_q)
      rdx_pkg::StIdle: begin
        q_ready_o = 1'b1;
        take_item = q_valid_i;
      end
      rdx_pkg::StInvalid: load_inval = slot_free;
      rdx_pkg::StSign:    load_sign  = slot_free;
      rdx_pkg::StDivide: begin
        div_run = 1'b1;
        push    = last_step;
      end
      rdx_pkg::StEmit: begin
        load_digit = slot_free;
        pop        = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    mag_d   = mag_q;
    rem_d   = rem_q;
    step_d  = step_q;
    depth_d = depth_q;
    if (take_item) begin
      mag_d  = q_item_i.mag;
      rem_d  = '0;
      step_d = '0;
    end else if (div_run) begin
      mag_d  = div_quot;
      rem_d  = last_step ? '0 : div_rem;
      step_d = last_step ? '0 : step_q + rdx_pkg::StepW'(1);
    end
    if (push) depth_d = depth_q + rdx_pkg::DepthW'(1);
    else if (pop) depth_d = depth_q - rdx_pkg::DepthW'(1);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_inval || load_sign || load_digit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdx_pkg::StIdle;
      step_q      <= '0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
  end

  // digit stack: digits arrive least significant first, leave from the top
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[0] <= div_rem;
      for (int k = 1; k < rdx_pkg::DataW; k++) stack_q[k] <= stack_q[k-1];
    end else if (pop) begin
      for (int k = 0; k < rdx_pkg::DataW - 1; k++) stack_q[k] <= stack_q[k+1];
    end
  end

  // the loads are exclusive by state; the register holds when none fires
  always_ff @(posedge clk_i) begin
    if (load_inval) begin
      out_char_q  <= rdx_pkg::CharNul;
      out_last_q  <= 1'b1;
      out_inval_q <= 1'b1;
    end else if (load_sign) begin
      out_char_q  <= rdx_pkg::CharMinus;
      out_last_q  <= 1'b0;
      out_inval_q <= 1'b0;
    end else if (load_digit) begin
      out_char_q  <= cfg_i.alpha[stack_q[0]];
      out_last_q  <= (depth_q == rdx_pkg::DepthW'(1));
      out_inval_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_inval_o = out_inval_q;

endmodule

[sv/radix_digit_emitter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_emitter_unit
// signed 32-bit value to digit characters in a configurable radix
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata[31:0] value
//  m_axis    | out       | tdata[7:0] character, tlast last, tuser invalid_base
//  cfg       | in        | index 0 alphabet_low, 1 alphabet_high, 2 base_length
//
// each value is divided by the radix once per digit in the 8-bit-per-cycle
// radix divider; the digits then leave the digit stack most significant
// first, after a minus sign for a negative value.
// an invalid alphabet gives one flagged character, via the output register.
// reset clears the configuration, so the alphabet is invalid until written.
// a two-entry queue takes further values while the digit engine is busy or
// the output stalls; the output register holds until taken.
// ----------------------------------------------------------------------------
module radix_digit_emitter_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rdx_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rdx_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,   // [31:0] value
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // [7:0] character
  output logic                         m_axis_tlast,
  output logic                         m_axis_tuser    // [0] invalid_base
);

  rdx_pkg::cfg_t  cfg;
  rdx_pkg::item_t fq_item, qb_item;
  logic           fq_valid, fq_ready;
  logic           qb_valid, qb_ready;

  rdx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata),
    .q_valid_o   (fq_valid),
    .q_ready_i   (fq_ready),
    .q_item_o    (fq_item),
    .cfg_o       (cfg)
  );

  rdx_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_valid),
    .in_ready_o  (fq_ready),
    .in_item_i   (fq_item),
    .out_valid_o (qb_valid),
    .out_ready_i (qb_ready),
    .out_item_o  (qb_item)
  );

  rdx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (qb_valid),
    .q_ready_o   (qb_ready),
    .q_item_i    (qb_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_inval_o (m_axis_tuser)
  );

endmodule

[sv/rdx_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdx_checker
// port-level checks on the emitted character stream
// ----------------------------------------------------------------------------
`include "radix_digit_emitter_unit_assert.svh"

module rdx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  logic       out_flag;
  logic       out_digit;
  logic       out_sign;
  logic       out_stall;
  logic [9:0] out_word;

  assign out_flag  = m_axis_tvalid && m_axis_tuser;
  assign out_digit = m_axis_tvalid && !m_axis_tuser;
  assign out_sign  = out_digit && m_axis_tdata == rdx_pkg::CharMinus;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tdata, m_axis_tlast, m_axis_tuser};

  // the invalid-alphabet result is a lone zero character
  `RDX_ASSERT_SAME(a_inval_alone, clk_i, rst_ni, out_flag, m_axis_tlast && m_axis_tdata == 8'h00)

  // a valid alphabet never holds a zero byte, so no digit reads as zero
  `RDX_ASSERT_SAME(a_char_nonzero, clk_i, rst_ni, out_digit, m_axis_tdata != rdx_pkg::CharNul)

  // a minus sign is always followed by digits
  `RDX_ASSERT_SAME(a_sign_not_last, clk_i, rst_ni, out_sign, !m_axis_tlast)

  // a stalled result holds
  `RDX_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_word))

endmodule

bind radix_digit_emitter_unit rdx_checker u_rdx_checker (.*);

[test/radix_digit_emitter_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_emitter_checker
// watches the configuration, value and character channels of the radix digit
// emitter, keeps its own copy of the alphabet registers, works out the
// characters each accepted value must produce and compares every accepted
// character against the oldest one still outstanding
// ----------------------------------------------------------------------------
module radix_digit_emitter_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [rdx_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rdx_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [31:0]                  s_tdata_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [7:0]                   m_tdata_i,
  input  logic                         m_tlast_i,
  input  logic                         m_tuser_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           values_seen_o,
  output int                           chars_seen_o,
  output int                           invalid_seen_o
);
  import rdx_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
    logic             invalid;
  } char_result_t;

  char_result_t     expected_chars[$];
  logic [CharW-1:0] alpha [AlphabetSize];
  logic [LenW-1:0]  radix;

  function automatic bit alphabet_ok();
    int i;
    int j;
    logic [CharW-1:0] c;
    if (radix < MinRadix || radix > AlphabetSize) return 1'b0;
    for (i = 0; i < radix; i++) begin
      c = alpha[i];
      if (c == CharNul || c == CharSpace || c == CharPlus || c == CharMinus ||
          (c >= CtrlLo && c <= CtrlHi)) return 1'b0;
      for (j = i + 1; j < radix; j++) begin
        if (alpha[j] == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void predict_chars(logic [DataW-1:0] value);
    logic [DataW-1:0] mag;
    int               digs [DataW];
    int               nd;
    int               i;
    char_result_t     r;
    nd = 0;
    if (!alphabet_ok()) begin
      r.ch      = CharNul;
      r.last    = 1'b1;
      r.invalid = 1'b1;
      expected_chars.push_back(r);
      return;
    end
    if (value[DataW-1]) begin
      // the most negative value wraps to magnitude 2^31 here
      mag       = -value;
      r.ch      = CharMinus;
      r.last    = 1'b0;
      r.invalid = 1'b0;
      expected_chars.push_back(r);
    end else begin
      mag = value;
    end
    do begin
      digs[nd] = int'(mag % radix);
      mag      = mag / radix;
      nd++;
    end while (mag != 0 && nd < DataW);
    for (i = nd - 1; i >= 0; i--) begin
      r.ch      = alpha[digs[i]];
      r.last    = (i == 0);
      r.invalid = 1'b0;
      expected_chars.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    char_result_t exp_r;
    char_result_t got_r;
    if (!rst_ni) begin
      for (int i = 0; i < AlphabetSize; i++) alpha[i] = '0;
      radix = '0;
      expected_chars.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      values_seen_o  = 0;
      chars_seen_o   = 0;
      invalid_seen_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgAlphaLow: begin
            for (int i = 0; i < 8; i++) alpha[i] = cfg_data_i[8*i +: 8];
          end
          CfgAlphaHigh: begin
            for (int i = 0; i < 8; i++) alpha[8 + i] = cfg_data_i[8*i +: 8];
          end
          CfgBaseLength: begin
            radix = cfg_data_i[LenW-1:0];
          end
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        chars_seen_o++;
        if (m_tuser_i) invalid_seen_o++;
        got_r.ch      = m_tdata_i;
        got_r.last    = m_tlast_i;
        got_r.invalid = m_tuser_i;
        if (expected_chars.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("checker: char %02h last %0b invalid %0b arrived with nothing expected",
                     got_r.ch, got_r.last, got_r.invalid);
        end else begin
          exp_r = expected_chars.pop_front();
          if (got_r !== exp_r) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("checker: %0t expected ch %02h l %0b i %0b, got ch %02h l %0b i %0b",
                       $time, exp_r.ch, exp_r.last, exp_r.invalid,
                       got_r.ch, got_r.last, got_r.invalid);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        values_seen_o++;
        predict_chars(s_tdata_i);
      end
      pending_o = expected_chars.size();
    end
  end

endmodule

[test/tb_radix_digit_emitter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_digit_emitter_unit
// drives values through the radix digit emitter under a series of alphabets:
// decimal, binary, hex with high bytes, every kind of broken alphabet, then
// random alphabets and random values with random stalls on both streams
// ----------------------------------------------------------------------------
module tb_radix_digit_emitter_unit;
  import rdx_pkg::*;

  localparam int CycleLimit  = 1_000_000;
  localparam int PauseCycles = 8;
  localparam int TailCycles  = 200;

  typedef enum int {
    FaultShort,
    FaultOversize,
    FaultForbidden,
    FaultDuplicate
  } fault_kind_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;

  int fail_count;
  int pending;
  int values_seen;
  int chars_seen;
  int invalid_seen;

  logic [CharW-1:0] digit_set [AlphabetSize];
  logic [LenW-1:0]  set_radix     = '0;
  bit               idle_on       = 1'b1;
  int               settings_used = 0;
  int               stall_left    = 0;
  int               cycle_count   = 0;

  always #5 clk_i = ~clk_i;

  radix_digit_emitter_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  radix_digit_emitter_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tlast_i     (m_axis_tlast),
    .m_tuser_i     (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .values_seen_o (values_seen),
    .chars_seen_o  (chars_seen),
    .invalid_seen_o(invalid_seen)
  );

  // character sink stalls in bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: timeout after %0d cycles, %0d characters outstanding",
               cycle_count, pending);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [CharW-1:0] forbidden_char(int k);
    case (k)
      0:       return CharNul;
      1:       return CharSpace;
      2:       return CharPlus;
      3:       return CharMinus;
      4:       return CtrlLo;
      5:       return CtrlHi;
      default: return CtrlLo + 8'd2;
    endcase
  endfunction

  function automatic bit bad_char(logic [CharW-1:0] c);
    return c == CharNul || c == CharSpace || c == CharPlus || c == CharMinus ||
           (c >= CtrlLo && c <= CtrlHi);
  endfunction

  function automatic void set_sequential(logic [CharW-1:0] first, int len);
    for (int i = 0; i < AlphabetSize; i++) digit_set[i] = first + CharW'(i);
    set_radix = LenW'(len);
  endfunction

  // distinct legal digits in use, anything at all in the unused slots
  function automatic void make_alphabet(int len);
    bit               used [256];
    logic [CharW-1:0] b;
    for (int i = 0; i < 256; i++) used[i] = 1'b0;
    for (int i = 0; i < AlphabetSize; i++) begin
      if (i < len) begin
        do b = CharW'($urandom_range(1, 255)); while (bad_char(b) || used[b]);
        used[b]      = 1'b1;
        digit_set[i] = b;
      end else begin
        digit_set[i] = CharW'($urandom);
      end
    end
    set_radix = LenW'(len);
  endfunction

  function automatic void make_faulty();
    int i;
    int j;
    make_alphabet($urandom_range(2, AlphabetSize));
    case (fault_kind_e'($urandom_range(0, 3)))
      FaultShort:    set_radix = LenW'($urandom_range(0, 1));
      FaultOversize: set_radix = LenW'($urandom_range(AlphabetSize + 1, 31));
      FaultForbidden: begin
        digit_set[$urandom_range(0, set_radix - 1)] = forbidden_char($urandom_range(0, 6));
      end
      default: begin
        i = $urandom_range(0, set_radix - 2);
        j = $urandom_range(i + 1, set_radix - 1);
        digit_set[j] = digit_set[i];
      end
    endcase
  endfunction

  function automatic logic [31:0] random_value();
    longint      p;
    int          r;
    int          k;
    int          sel;
    logic [31:0] v;
    r   = (set_radix >= MinRadix && set_radix <= AlphabetSize) ? int'(set_radix) : 10;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: v = $urandom;
      4:          v = $urandom_range(0, 300);
      5: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h0000_0000;
          1:       v = 32'hFFFF_FFFF;
          2:       v = 32'h0000_0001;
          3:       v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      6: begin
        // near a power of the radix, where the digit count steps
        p = 1;
        k = $urandom_range(1, 31);
        while (k > 0 && p * r <= 64'h8000_0000) begin
          p = p * r;
          k--;
        end
        v = 32'(p) + 32'($urandom_range(0, 2)) - 32'd1;
      end
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if (sel >= 4 && sel != 5 && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  task automatic send_value(logic [31:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (PauseCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // registers only change once every outstanding character has come back
  task automatic load_alphabet();
    logic [CfgDataW-1:0] lo;
    logic [CfgDataW-1:0] hi;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = digit_set[i];
      hi[8*i +: 8] = digit_set[8 + i];
    end
    quiesce();
    write_reg(CfgAlphaLow, lo);
    write_reg(CfgAlphaHigh, hi);
    write_reg(CfgBaseLength, CfgDataW'(set_radix));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  initial begin
    bit faulty;
    for (int i = 0; i < AlphabetSize; i++) digit_set[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers still at reset: radix zero, every value is flagged
    send_value(32'd5);
    send_value(32'h8000_0000);

    set_sequential("0", 10);
    load_alphabet();
    send_value(32'd0);
    send_value(32'd7);
    send_value(32'hFFFF_FFFF);
    send_value(32'd10);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(-32'sd123456789);

    // binary: the most negative value gives a sign and 32 digits
    set_sequential("0", 2);
    load_alphabet();
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);

    // full radix with digits above 127
    set_sequential(8'hF0, 16);
    load_alphabet();
    send_value(32'hDEAD_BEEF);
    send_value(32'h7FFF_FFFF);

    set_sequential("0", 1);
    load_alphabet();
    send_value(32'd3);
    set_sequential("0", 17);
    load_alphabet();
    send_value(32'd3);
    set_sequential("0", 31);
    load_alphabet();
    send_value(32'd3);

    for (int k = 0; k < 7; k++) begin
      set_sequential("0", 10);
      digit_set[(k * 3) % 10] = forbidden_char(k);
      load_alphabet();
      send_value(-32'sd42);
    end

    set_sequential("0", 10);
    digit_set[9] = digit_set[2];
    load_alphabet();
    send_value(32'd1000);

    for (int ph = 0; ph < 15; ph++) begin
      idle_on = (ph < 12) ? ($urandom_range(0, 3) != 0) : 1'b0;
      faulty  = 1'b0;
      if (ph == 0) begin
        make_alphabet(MinRadix);
      end else if (ph == 1) begin
        make_alphabet(AlphabetSize);
      end else if ($urandom_range(0, 3) == 0) begin
        make_faulty();
        faulty = 1'b1;
      end else begin
        make_alphabet($urandom_range(MinRadix, AlphabetSize));
      end
      load_alphabet();
      repeat (faulty ? 6 : 26) send_value(random_value());
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (TailCycles) @(posedge clk_i);

    $display("tb: %0d values turned into %0d characters under %0d alphabet settings",
             values_seen, chars_seen, settings_used);
    $display("tb: %0d of those results carried the bad-alphabet flag, %0d mismatches",
             invalid_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
